// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define SIC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg
// types, codes and sizes shared by the site classifier modules
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int DEF_MAX_TAXA   = 64;
    localparam int DEF_NUM_STATES = 16;

    // queue between front and back, power of two so the pointers wrap
    localparam int QUEUE_DEPTH = 4;

    localparam int READ_W     = 4;
    localparam int CNT_W      = 7;
    localparam int MASK_W     = 64;
    localparam int MASK_IDX_W = 6;
    localparam int DIST_OUT_W = 5;
    localparam int TYPE_W     = 2;

    localparam logic [TYPE_W-1:0] SITE_CONSTANT    = 2'd0;
    localparam logic [TYPE_W-1:0] SITE_SINGULAR    = 2'd1;
    localparam logic [TYPE_W-1:0] SITE_INFORMATIVE = 2'd2;

    typedef struct packed {
        logic [READ_W-1:0] reading;
        logic              last_taxon;
    } t_item;

    typedef struct packed {
        logic [TYPE_W-1:0]     site_type;
        logic [READ_W-1:0]     majority_state;
        logic [MASK_W-1:0]     singular_mask;
        logic [DIST_OUT_W-1:0] distinct_states;
        logic                  taxa_overflow;
    } t_result;

    // classified item as it travels through the queue
    typedef struct packed {
        logic [READ_W-1:0] reading;
        logic              counted;
        logic              last_taxon;
    } t_entry;

    // queue status seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qhead;

endpackage

// ===== sv/sic_front.sv =====
// ----------------------------------------------------------------------------
// sic_front
// accepts items, holds the missing code and marks whether each reading is counted
// ----------------------------------------------------------------------------
module sic_front #(
    parameter int NUM_STATES = sic_pkg::DEF_NUM_STATES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  sic_pkg::t_item             i_item,
    input  logic                       i_cfg_we,
    input  logic [sic_pkg::READ_W-1:0] i_cfg_wdata,
    input  logic                       i_full,
    output logic                       o_busy,
    output logic                       o_push,
    output sic_pkg::t_entry            o_entry
);
    import sic_pkg::*;

    localparam logic [READ_W:0] STATE_LIM = (READ_W+1)'(NUM_STATES);

    logic [READ_W-1:0] r_missing;
    logic              in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_missing <= '0;
        end else if (i_cfg_we) begin
            r_missing <= i_cfg_wdata;
        end
    end

    // out-of-range states count as missing
    assign in_range = {1'b0, i_item.reading} < STATE_LIM;

    assign o_busy             = i_full;
    assign o_push             = i_start && !i_full;
    assign o_entry.reading    = i_item.reading;
    assign o_entry.counted    = in_range && (i_item.reading != r_missing);
    assign o_entry.last_taxon = i_item.last_taxon;

endmodule

// ===== sv/sic_queue.sv =====
// ----------------------------------------------------------------------------
// sic_queue
// short item queue that decouples the front from the back end
// ----------------------------------------------------------------------------
module sic_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sic_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output sic_pkg::t_qhead o_head
);
    import sic_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [QCNT_W-1:0]   r_fill;
    logic                do_pop;

    assign do_pop = i_pop && (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + QCNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_fill <= r_fill - QCNT_W'(1);
            end
        end
    end

    assign o_full       = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_fill != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

endmodule

// ===== sv/sic_back.sv =====
// ----------------------------------------------------------------------------
// sic_back
// counts states per column, then walks the states in first-seen order
// ----------------------------------------------------------------------------
module sic_back #(
    parameter int MAX_TAXA   = sic_pkg::DEF_MAX_TAXA,
    parameter int NUM_STATES = sic_pkg::DEF_NUM_STATES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sic_pkg::t_qhead  i_head,
    output logic             o_pop,
    output logic             o_done,
    output sic_pkg::t_result o_result
);
    import sic_pkg::*;

    localparam int SIDX_W = $clog2(NUM_STATES);
    localparam int TIDX_W = $clog2(MAX_TAXA);
    localparam int TCNT_W = $clog2(MAX_TAXA + 1);
    localparam int DCNT_W = $clog2(NUM_STATES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_WALK = 2'b10
    } t_back_state;

    t_back_state        r_state;
    logic [CNT_W-1:0]   r_cnt         [NUM_STATES];
    logic [SIDX_W-1:0]  r_seen        [NUM_STATES];
    logic [TIDX_W-1:0]  r_first_taxon [NUM_STATES];
    logic [TCNT_W-1:0]  r_taxon_cnt;
    logic [DCNT_W-1:0]  r_distinct;
    logic               r_ovf;
    logic [SIDX_W-1:0]  r_k;
    logic [CNT_W-1:0]   r_best;
    logic [SIDX_W-1:0]  r_major;
    logic [DCNT_W-1:0]  r_doubles;
    logic [MASK_W-1:0]  r_mask;
    logic               r_done;
    t_result            r_result;

    logic [SIDX_W-1:0]  rd_idx;
    logic [CNT_W-1:0]   cur_cnt;
    logic               room;
    logic               take;
    logic [CNT_W-1:0]   n_best;
    logic [SIDX_W-1:0]  n_major;
    logic [DCNT_W-1:0]  n_doubles;
    logic [MASK_W-1:0]  n_mask;
    logic               few;
    logic               walk_end;
    t_result            n_result;

    assign o_pop = (r_state == S_LOAD) && i_head.valid;

    // one shared read port on the count table: loading or walking
    assign rd_idx  = (r_state == S_WALK) ? r_seen[r_k] : i_head.entry.reading[SIDX_W-1:0];
    assign cur_cnt = r_cnt[rd_idx];
    assign room    = r_taxon_cnt < TCNT_W'(MAX_TAXA);

    always_comb begin
        take      = cur_cnt > r_best;
        n_best    = take ? cur_cnt : r_best;
        n_major   = take ? rd_idx : r_major;
        n_doubles = r_doubles + ((cur_cnt >= CNT_W'(2)) ? DCNT_W'(1) : DCNT_W'(0));
        n_mask    = r_mask;
        if (cur_cnt == CNT_W'(1)) begin
            n_mask = r_mask | (MASK_W'(1) << MASK_IDX_W'(r_first_taxon[rd_idx]));
        end
        few      = r_distinct < DCNT_W'(2);
        walk_end = few || ((DCNT_W'(r_k) + DCNT_W'(1)) == r_distinct);

        n_result.distinct_states = DIST_OUT_W'(r_distinct);
        n_result.taxa_overflow   = r_ovf;
        if (few) begin
            n_result.site_type      = SITE_CONSTANT;
            n_result.majority_state = '0;
            n_result.singular_mask  = '0;
        end else begin
            n_result.site_type      = (n_doubles <= DCNT_W'(1)) ? SITE_SINGULAR
                                                                : SITE_INFORMATIVE;
            n_result.majority_state = READ_W'(n_major);
            n_result.singular_mask  = n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_taxon_cnt <= '0;
            r_distinct  <= '0;
            r_ovf       <= 1'b0;
            r_done      <= 1'b0;
            for (int i = 0; i < NUM_STATES; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (o_pop) begin
                        if (!room) begin
                            r_ovf <= 1'b1;
                        end else begin
                            if (i_head.entry.counted) begin
                                if (cur_cnt == '0) begin
                                    r_seen[r_distinct[SIDX_W-1:0]] <= rd_idx;
                                    r_first_taxon[rd_idx] <= r_taxon_cnt[TIDX_W-1:0];
                                    r_distinct <= r_distinct + DCNT_W'(1);
                                end
                                if (cur_cnt != CNT_MAX) begin
                                    r_cnt[rd_idx] <= cur_cnt + CNT_W'(1);
                                end
                            end
                            r_taxon_cnt <= r_taxon_cnt + TCNT_W'(1);
                        end
                        if (i_head.entry.last_taxon) begin
                            r_state   <= S_WALK;
                            r_k       <= '0;
                            r_best    <= '0;
                            r_major   <= '0;
                            r_doubles <= '0;
                            r_mask    <= '0;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_end) begin
                        r_done      <= 1'b1;
                        r_result    <= n_result;
                        r_taxon_cnt <= '0;
                        r_distinct  <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_LOAD;
                        for (int i = 0; i < NUM_STATES; i++) begin
                            r_cnt[i] <= '0;
                        end
                    end else begin
                        r_k       <= r_k + SIDX_W'(1);
                        r_best    <= n_best;
                        r_major   <= n_major;
                        r_doubles <= n_doubles;
                        r_mask    <= n_mask;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== sv/site_informativeness_classifier_core.sv =====
// ----------------------------------------------------------------------------
// site_informativeness_classifier_core
// classifies one alignment column as constant, singular or informative
// ----------------------------------------------------------------------------
// usage
//   items: one reading per taxon on i_item, taken when start is high and busy
//   is low; last_taxon closes the column. busy rises only when the four-entry
//   item queue is full.
//   config: i_cfg_we writes the missing code from i_cfg_wdata.
//   results: one per column on o_result, valid for the single cycle o_done is
//   high; the receiver cannot stall, so nothing holds results back.
// timing
//   the back end takes one queued reading per cycle while any are queued, then
//   walks the column's distinct states in first-seen order, one state per cycle
//   (when fewer than two states, the first step ends the walk). o_done rises
//   the cycle after the final walk step. readings queue up while a walk runs.
// reset
//   synchronous, active low: queue emptied, counts cleared, missing code 0.
// ----------------------------------------------------------------------------
module site_informativeness_classifier_core #(
    parameter int MAX_TAXA   = sic_pkg::DEF_MAX_TAXA,
    parameter int NUM_STATES = sic_pkg::DEF_NUM_STATES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sic_pkg::t_item             i_item,
    input  logic                       i_cfg_we,
    input  logic [sic_pkg::READ_W-1:0] i_cfg_wdata,
    output logic                       o_done,
    output sic_pkg::t_result           o_result
);
    import sic_pkg::*;

    logic   full;
    logic   push;
    logic   pop;
    t_entry entry;
    t_qhead head;

    sic_front #(
        .NUM_STATES (NUM_STATES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_full      (full),
        .o_busy      (busy),
        .o_push      (push),
        .o_entry     (entry)
    );

    sic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    sic_back #(
        .MAX_TAXA   (MAX_TAXA),
        .NUM_STATES (NUM_STATES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== sv/sic_checker.sv =====
// ----------------------------------------------------------------------------
// sic_checker
// port-level checks on the classifier results and busy, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sic_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input sic_pkg::t_result o_result
);
    import sic_pkg::*;

    logic is_const;
    logic accepted;
    logic const_clean;
    logic multi_state;
    logic mask_fits;

    assign is_const    = (o_result.site_type == SITE_CONSTANT);
    assign accepted    = start && !busy;
    assign const_clean = (o_result.majority_state == '0) && (o_result.singular_mask == '0);
    assign multi_state = (o_result.distinct_states >= DIST_OUT_W'(2));
    assign mask_fits   = ($countones(o_result.singular_mask) <= 32'(o_result.distinct_states));

    // a constant site carries no majority and no mask
    `SIC_ASSERT_IMP(a_const_clean, i_clk, i_rst_n, o_done && is_const, const_clean)

    // a non-constant site has at least two states
    `SIC_ASSERT_IMP(a_multi_state, i_clk, i_rst_n, o_done && !is_const, multi_state)

    // the singular mask has no more bits set than there are distinct states
    `SIC_ASSERT_IMP(a_mask_bound, i_clk, i_rst_n, o_done, mask_fits)

    // a walk step always sits between two results
    `SIC_ASSERT_NXT(a_no_back_to_back, i_clk, i_rst_n, o_done, !o_done)

    // busy only rises when an item is taken
    `SIC_ASSERT_NXT(a_ready_after_rst, i_clk, i_rst_n, !busy && !accepted, !busy)

endmodule

bind site_informativeness_classifier_core sic_checker u_sic_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
